// ===== design/rbd_pkg.sv =====
// Shared types, register codes and sum helpers for the RGBA box downsampler.
`default_nettype none

package rbd_pkg;

  localparam int SUM_W      = 12;
  localparam int IMG_W_BITS = 12;
  localparam int IMG_H_BITS = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MIN_SIZE   = 4;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [IMG_W_BITS-1:0] WIDTH_RST  = 12'd64;
  localparam logic [IMG_H_BITS-1:0] HEIGHT_RST = 13'd64;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd1;
  localparam cfg_idx_t REG_SHRINK_MODE  = 2'd2;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_last;
  } pixel_out_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] alpha;
  } chan_sum_t;

  // Where the pixel sits inside its block, decided at accept time.
  typedef struct packed {
    logic in_block;   // inside the used area
    logic seg_first;  // first column of a block
    logic seg_last;   // last column of a block
    logic row_first;  // first row of a block
    logic row_last;   // last row of a block
    logic frame_end;  // bottom-right pixel of the last block
    logic mode4;      // 4x4 averaging
  } pos_flags_t;

  function automatic chan_sum_t pix_to_sum(input pixel_in_t p);
    chan_sum_t s;
    s.red   = SUM_W'(p.red_in);
    s.green = SUM_W'(p.green_in);
    s.blue  = SUM_W'(p.blue_in);
    s.alpha = SUM_W'(p.alpha_in);
    return s;
  endfunction

  function automatic chan_sum_t sum_add(input chan_sum_t a, input chan_sum_t b);
    chan_sum_t s;
    s.red   = a.red + b.red;
    s.green = a.green + b.green;
    s.blue  = a.blue + b.blue;
    s.alpha = a.alpha + b.alpha;
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/rbd_pos_track.sv =====
// Config registers and raster position counters; flags each accepted pixel.
`default_nettype none

module rbd_pos_track
  import rbd_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_valid,
  input  wire cfg_idx_t                 cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                     in_accept,
  output pos_flags_t                    flags,
  output logic [$clog2(MAX_WIDTH/2)-1:0] blk_addr
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ADDR_W = $clog2(MAX_WIDTH / 2);
  localparam int LEN_W  = ($clog2(MAX_WIDTH + 1) > IMG_W_BITS) ?
                          $clog2(MAX_WIDTH + 1) : IMG_W_BITS;

  logic [IMG_W_BITS-1:0] img_width_r;
  logic [IMG_H_BITS-1:0] img_height_r;
  logic                  mode_r;
  logic [COL_W-1:0]      col_r;
  logic [ROW_W-1:0]      row_r;

  logic [LEN_W-1:0]      width_ext;
  logic [LEN_W-1:0]      len_eff;
  logic [LEN_W-1:0]      used_w;
  logic [LEN_W-1:0]      col_ext;
  logic [LEN_W-1:0]      col_inc;
  logic [IMG_H_BITS-1:0] hgt_eff;
  logic [IMG_H_BITS-1:0] used_h;
  logic [IMG_H_BITS-1:0] row_ext;
  logic [IMG_H_BITS-1:0] row_inc;
  logic [COL_W-1:0]      blk_idx;
  logic                  line_end;
  logic                  frame_wrap;

  always_comb begin
    width_ext = LEN_W'(img_width_r);
    if (width_ext < LEN_W'(MIN_SIZE)) begin
      len_eff = LEN_W'(MIN_SIZE);
    end else if (width_ext > LEN_W'(MAX_WIDTH)) begin
      len_eff = LEN_W'(MAX_WIDTH);
    end else begin
      len_eff = width_ext;
    end

    if (img_height_r < IMG_H_BITS'(MIN_SIZE)) begin
      hgt_eff = IMG_H_BITS'(MIN_SIZE);
    end else if (img_height_r > IMG_H_BITS'(MAX_HEIGHT)) begin
      hgt_eff = IMG_H_BITS'(MAX_HEIGHT);
    end else begin
      hgt_eff = img_height_r;
    end

    // Drop trailing columns and rows that do not fill a block
    used_w = mode_r ? {len_eff[LEN_W-1:2], 2'b00} : {len_eff[LEN_W-1:1], 1'b0};
    used_h = mode_r ? {hgt_eff[IMG_H_BITS-1:2], 2'b00}
                    : {hgt_eff[IMG_H_BITS-1:1], 1'b0};

    col_ext = LEN_W'(col_r);
    col_inc = col_ext + LEN_W'(1);
    row_ext = IMG_H_BITS'(row_r);
    row_inc = row_ext + IMG_H_BITS'(1);

    flags.in_block  = (col_ext < used_w) && (row_ext < used_h);
    flags.seg_first = mode_r ? (col_r[1:0] == 2'b00) : !col_r[0];
    flags.seg_last  = mode_r ? (col_r[1:0] == 2'b11) : col_r[0];
    flags.row_first = mode_r ? (row_r[1:0] == 2'b00) : !row_r[0];
    flags.row_last  = mode_r ? (row_r[1:0] == 2'b11) : row_r[0];
    flags.frame_end = (col_inc == used_w) && (row_inc == used_h);
    flags.mode4     = mode_r;

    blk_idx  = mode_r ? (col_r >> 2) : (col_r >> 1);
    blk_addr = blk_idx[ADDR_W-1:0];

    line_end   = (col_inc >= len_eff);
    frame_wrap = (row_inc >= hgt_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= WIDTH_RST;
      img_height_r <= HEIGHT_RST;
      mode_r       <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          img_width_r <= cfg_data[IMG_W_BITS-1:0];
          col_r       <= '0;
          row_r       <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          img_height_r <= cfg_data;
          col_r        <= '0;
          row_r        <= '0;
        end
        REG_SHRINK_MODE: begin
          mode_r <= cfg_data[0];
          col_r  <= '0;
          row_r  <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_accept) begin
      if (line_end) begin
        col_r <= '0;
        row_r <= frame_wrap ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/rbd_line_store.sv =====
// Line store of per-block column sums, one write and one registered read port.
`default_nettype none

module rbd_line_store
  import rbd_pkg::*;
#(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire chan_sum_t         wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output chan_sum_t              rd_data
);

  chan_sum_t mem [DEPTH];
  chan_sum_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/rbd_accum.sv =====
// Pixel register, row and column accumulation, and the result register.
`default_nettype none

module rbd_accum
  import rbd_pkg::*;
#(
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pixel_in_t         in_data,
  input  wire pos_flags_t        flags_in,
  input  wire logic [ADDR_W-1:0] addr_in,
  input  wire chan_sum_t         rd_data,
  output logic                   wr_en,
  output logic [ADDR_W-1:0]      wr_addr,
  output chan_sum_t              wr_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pixel_out_t             out_pixel
);

  logic              s1_valid_r;
  pixel_in_t         pix_r;
  pos_flags_t        flags_r;
  logic [ADDR_W-1:0] addr_r;
  chan_sum_t         psum_r;
  logic              out_valid_r;
  pixel_out_t        out_r;

  logic       out_free;
  logic       fire;
  logic       emit;
  chan_sum_t  psum_nxt;
  chan_sum_t  entry;
  pixel_out_t out_nxt;

  assign out_free = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || fire;

  always_comb begin
    psum_nxt = flags_r.seg_first ? pix_to_sum(pix_r) : sum_add(psum_r, pix_to_sum(pix_r));
    // First row of a block overwrites; stale store contents are never used
    entry    = flags_r.row_first ? psum_nxt : sum_add(rd_data, psum_nxt);
    wr_en    = fire && flags_r.in_block && flags_r.seg_last;
    emit     = wr_en && flags_r.row_last;

    if (flags_r.mode4) begin
      out_nxt.red_out   = entry.red[11:4];
      out_nxt.green_out = entry.green[11:4];
      out_nxt.blue_out  = entry.blue[11:4];
      out_nxt.alpha_out = entry.alpha[11:4];
    end else begin
      out_nxt.red_out   = entry.red[9:2];
      out_nxt.green_out = entry.green[9:2];
      out_nxt.blue_out  = entry.blue[9:2];
      out_nxt.alpha_out = entry.alpha[9:2];
    end
    out_nxt.frame_last = flags_r.frame_end;
  end

  assign wr_addr   = addr_r;
  assign wr_data   = entry;
  assign out_valid = out_valid_r;
  assign out_pixel = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pix_r   <= in_data;
      flags_r <= flags_in;
      addr_r  <= addr_in;
    end
    if (fire && flags_r.in_block) begin
      psum_r <= psum_nxt;
    end
    if (fire && emit) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/rgba_box_downsampler.sv =====
// Top level of the RGBA8 2x2 / 4x4 box-filter mip generator.
`default_nettype none

// RGBA8 pixels enter in raster order, one item per clock when out_ready is
// high; each output channel is the truncated mean of a 2x2 block
// (shrink_mode = 0) or a 4x4 block (shrink_mode = 1). One result item is
// registered when the bottom-right pixel of a block leaves the pixel register,
// and frame_last marks the last block of the frame. Sustained rate is one item
// per cycle while out_ready is high: the only per-item loop is the
// read-add-write of the column-sum line store, whose read is issued at accept
// and whose write lands when that item leaves the pixel register, before the
// next read of the same entry can occur. Trailing columns/rows that do not
// fill a block are consumed with no result. Register indexes: 0 image_width
// (clamped to 4..MAX_WIDTH), 1 image_height (clamped to 4..4096),
// 2 shrink_mode; index 3 is ignored. Any valid register write restarts the
// frame. Write config only while idle. The line store holds MAX_WIDTH/2
// entries, needs no clearing after reset, and cfg_ready is always high.

module rgba_box_downsampler
  import rbd_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire pixel_in_t             in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output pixel_out_t                 out_pixel,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire cfg_idx_t              cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int STORE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  logic              in_accept;
  pos_flags_t        flags;
  logic [ADDR_W-1:0] blk_addr;
  logic              rd_en;
  chan_sum_t         rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  chan_sum_t         wr_data;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;

  // Fetch the running column sum only for the item that closes a block row
  assign rd_en = in_accept && flags.in_block && flags.seg_last;

  rbd_pos_track #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .flags     (flags),
    .blk_addr  (blk_addr)
  );

  rbd_line_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (blk_addr),
    .rd_data (rd_data)
  );

  rbd_accum #(
    .ADDR_W (ADDR_W)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .flags_in  (flags),
    .addr_in   (blk_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pixel (out_pixel)
  );

endmodule

`default_nettype wire

// ===== sim/rgba_box_downsampler_test.sv =====
// Self-checking testbench for the RGBA8 2x2 / 4x4 box-filter mip generator.
`timescale 1ns / 1ps

module rgba_box_downsampler_test;
  import rbd_pkg::*;

  localparam int LINE_MAX    = 2048;          // widest line the block takes
  localparam int STORE_DEPTH = LINE_MAX / 2;  // one column-sum entry per output column
  localparam int STALL_LIMIT = 4000;          // cycles with no handshake before giving up
  localparam int DRAIN_TAIL  = 8;             // margin for items that make no result but are still in flight
  localparam int RX_HOLD     = 500;           // long receiver hold-off

  // Index past the end of the register list; writes to it are dropped.
  localparam cfg_idx_t REG_UNUSED = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pixel_in_t             in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pixel_out_t            out_pixel;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Idle percentages for both sides, changed per stage of the run.
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned rx_hold_len  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_count    = 0;

  // Predictor copy of the registers and the block's position/sum state.
  logic [IMG_W_BITS-1:0] img_width;
  logic [IMG_H_BITS-1:0] img_height;
  logic                  avg4;
  int unsigned           col_pos;
  int unsigned           row_pos;
  logic [11:0]           seg_sum [4];
  logic [11:0]           line_sums [STORE_DEPTH][4];
  pixel_out_t            pending_mips [$];

  rgba_box_downsampler #(
    .MAX_WIDTH(LINE_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pixel(out_pixel),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic restart_position();
    col_pos = 0;
    row_pos = 0;
    foreach (seg_sum[c]) seg_sum[c] = '0;
  endtask

  // Folds one accepted pixel into the running sums and queues the mip pixel
  // when it closes a block. Position advances over the full clamped line and
  // frame, so trailing partial columns/rows are consumed with no result.
  task automatic average_block(input pixel_in_t px);
    int unsigned lg, fmask, line_len, frame_rows, blocks_across, used_w, used_h, slot;
    logic [7:0]  chan [4];
    pixel_out_t  mip;
    lg         = avg4 ? 2 : 1;
    fmask      = (1 << lg) - 1;
    line_len   = (img_width < MIN_SIZE) ? MIN_SIZE :
                 (img_width > LINE_MAX) ? LINE_MAX : img_width;
    frame_rows = (img_height < MIN_SIZE) ? MIN_SIZE :
                 (img_height > MAX_HEIGHT) ? MAX_HEIGHT : img_height;
    blocks_across = line_len >> lg;
    used_w        = blocks_across << lg;
    used_h        = (frame_rows >> lg) << lg;
    chan = '{px.red_in, px.green_in, px.blue_in, px.alpha_in};

    if (col_pos < used_w && row_pos < used_h) begin
      // horizontal partial sum across the block's columns
      foreach (chan[c])
        seg_sum[c] = ((col_pos & fmask) == 0) ? 12'(chan[c]) : seg_sum[c] + 12'(chan[c]);
      if ((col_pos & fmask) == fmask) begin
        slot = (col_pos >> lg) % STORE_DEPTH;
        // first row of a block overwrites the column entry, later rows add
        foreach (chan[c])
          line_sums[slot][c] = ((row_pos & fmask) == 0) ? seg_sum[c]
                                                        : line_sums[slot][c] + seg_sum[c];
        if ((row_pos & fmask) == fmask) begin
          mip.red_out    = 8'(line_sums[slot][0] >> (2 * lg));
          mip.green_out  = 8'(line_sums[slot][1] >> (2 * lg));
          mip.blue_out   = 8'(line_sums[slot][2] >> (2 * lg));
          mip.alpha_out  = 8'(line_sums[slot][3] >> (2 * lg));
          mip.frame_last = ((col_pos >> lg) == blocks_across - 1) && (row_pos == used_h - 1);
          pending_mips.push_back(mip);
        end
      end
    end

    if (col_pos + 1 >= line_len) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= frame_rows) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  // Samples every handshake at the rising edge, before the edge's own updates
  // land, so config, input and result are seen in a fixed order.
  always @(posedge clk) begin : monitor
    pixel_out_t want;
    if (!rst_n) begin
      img_width  = WIDTH_RST;
      img_height = HEIGHT_RST;
      avg4       = 1'b0;
      restart_position();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  img_width  = cfg_data[IMG_W_BITS-1:0];
          REG_IMAGE_HEIGHT: img_height = cfg_data[IMG_H_BITS-1:0];
          REG_SHRINK_MODE:  avg4       = cfg_data[0];
          default: ;
        endcase
        // any write to a real register restarts the frame
        if (cfg_index != REG_UNUSED) restart_position();
      end
      if (in_valid && in_ready) average_block(in_data);
      if (out_valid && out_ready) begin
        if (pending_mips.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("result item with nothing expected: %h", out_pixel);
        end else begin
          want = pending_mips.pop_front();
          check_field("red_out",    want.red_out,    out_pixel.red_out);
          check_field("green_out",  want.green_out,  out_pixel.green_out);
          check_field("blue_out",   want.blue_out,   out_pixel.blue_out);
          check_field("alpha_out",  want.alpha_out,  out_pixel.alpha_out);
          check_field("frame_last", 8'(want.frame_last), 8'(out_pixel.frame_last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver and watchdog
  // ---------------------------------------------------------------------------

  // Random stalls per the current stage; a requested hold-off wins.
  always @(posedge clk) begin
    if (rx_hold_len != 0) begin
      out_ready   <= 1'b0;
      rx_hold_len <= rx_hold_len - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Ends the run when no channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Valid stays up between back-to-back items; at random it drops before an item.
  task automatic send_pixel(input pixel_in_t px);
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(pixel_in_t'($urandom));
  endtask

  // Lets every queued mip pixel come out, then waits out the drain tail for
  // items that make no result but may still be in flight.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_mips.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Unused upper data bits get random filler; the block must ignore them.
  task automatic set_geometry(input logic [IMG_W_BITS-1:0] w, input logic [IMG_H_BITS-1:0] h,
                              input logic mode4);
    write_reg(REG_IMAGE_WIDTH, {1'($urandom), w});
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_SHRINK_MODE, {12'($urandom), mode4});
  endtask

  task automatic set_idling(input int unsigned in_pct, input int unsigned out_pct);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset geometry is 64 wide, 2x2: two rows give 32 mip pixels.
  task automatic test_reset_defaults();
    send_random(2 * 64);
    wait_drain();
  endtask

  // Full-scale and zero pixels in both modes; the 4x4 block has one black
  // pixel so the truncating shift shows (15 * 255 / 16).
  task automatic test_directed_extremes();
    pixel_in_t px;
    set_geometry(12'd4, 13'd4, 1'b1);
    for (int k = 0; k < 16; k++) begin
      px = '1;
      if (k == 5) px = '0;
      send_pixel(px);
    end
    wait_drain();
    set_geometry(12'd4, 13'd4, 1'b0);
    // two rows: left block all zero, right block all full scale
    for (int k = 0; k < 8; k++) begin
      px = ((k % 4) < 2) ? '0 : '1;
      send_pixel(px);
    end
    wait_drain();
  endtask

  // Sizes that leave trailing columns and rows; one frame each plus a few
  // items so the wrap into the next frame is covered.
  task automatic test_partial_blocks();
    int unsigned dims [3][3];
    dims = '{'{7, 5, 0}, '{10, 7, 1}, '{6, 9, 1}};
    foreach (dims[k]) begin
      set_geometry(12'(dims[k][0]), 13'(dims[k][1]), 1'(dims[k][2]));
      send_random(dims[k][0] * dims[k][1] + 3);
      wait_drain();
    end
  endtask

  // Mid-frame rewrites of each register with its current value: only the
  // restart is visible. The unused index must leave the frame running.
  task automatic test_register_restart();
    cfg_idx_t              order [4];
    logic [CFG_DATA_W-1:0] same_val;
    order = '{REG_SHRINK_MODE, REG_UNUSED, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT};
    for (int m = 0; m < 2; m++) begin
      set_geometry(12'd6, 13'd8, 1'(m));
      foreach (order[k]) begin
        send_random($urandom_range(5, 30));
        wait_drain();
        case (order[k])
          REG_IMAGE_WIDTH:  same_val = 13'd6;
          REG_IMAGE_HEIGHT: same_val = 13'd8;
          REG_SHRINK_MODE:  same_val = 13'(m);
          default:          same_val = 13'($urandom);
        endcase
        write_reg(order[k], same_val);
      end
      send_random(40);
      wait_drain();
    end
  endtask

  // Width and height below the minimum clamp to a 4x4 frame.
  task automatic test_size_clamp();
    for (int m = 0; m < 2; m++) begin
      set_geometry(12'($urandom_range(0, 3)), 13'($urandom_range(0, 3)), 1'(m));
      send_random(40);
      wait_drain();
    end
  endtask

  // Small random geometries, random item counts that can end mid-frame.
  task automatic test_random_frames(input int unsigned budget);
    int unsigned sent, w, h, count;
    logic        mode4;
    sent = 0;
    while (sent < budget) begin
      mode4 = 1'($urandom_range(1));
      w     = $urandom_range(4, 24);
      h     = $urandom_range(4, 12);
      set_geometry(12'(w), 13'(h), mode4);
      count = $urandom_range(w * h / 2, 2 * w * h + w);
      send_random(count);
      sent += count;
      wait_drain();
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the block fills
  // and stalls its input; then the sender pauses mid-frame until all is out.
  task automatic test_backpressure();
    set_geometry(12'd4, 13'd64, 1'b0);
    rx_hold_len = RX_HOLD;
    send_random(200);
    wait_drain();
    send_random(37);
    wait_drain();
    send_random(60);
    wait_drain();
  endtask

  // All-ones width clamps to the widest line and all-ones height to the tallest
  // frame; a partial first row of it closes no block and must give no result.
  task automatic test_widest_line();
    set_geometry('1, '1, 1'b0);
    send_random(150);
    wait_drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(27, 56);
    test_reset_defaults();
    test_directed_extremes();
    test_partial_blocks();
    test_random_frames(150);

    set_idling(56, 27);
    test_register_restart();
    test_size_clamp();
    test_random_frames(150);

    set_idling(0, 0);
    test_backpressure();
    test_widest_line();
    test_random_frames(100);

    wait_drain();
    if (err_count == 0 && pending_mips.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rbd_pkg.sv
design/rbd_pos_track.sv
design/rbd_line_store.sv
design/rbd_accum.sv
design/rgba_box_downsampler.sv
sim/rgba_box_downsampler_test.sv
